### design/magstripe_f2f_transmitter_defines.svh
// Assertion helpers for the magnetic-stripe transmitter.
`ifndef MAGSTRIPE_F2F_TRANSMITTER_DEFINES_SVH
`define MAGSTRIPE_F2F_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MF2F_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MF2F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mf2f_pkg.sv
package mf2f_pkg;

  // Field and register widths.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned BPC_W       = 4;
  localparam int unsigned PAD_W       = 6;

  // Default sizes for the top-level parameters.
  localparam int unsigned MAX_PAD_CELLS_DEF = 32;
  localparam int unsigned MAX_CHAR_BITS_DEF = 8;

  // Register reset values.
  localparam logic [BPC_W-1:0]  BPC_RST       = BPC_W'(7);
  localparam logic [PAD_W-1:0]  PREAMBLE_RST  = PAD_W'(28);
  localparam logic [PAD_W-1:0]  TRAILER_RST   = PAD_W'(28);
  localparam logic [CHAR_W-1:0] STOP_CHAR_RST = CHAR_W'(70);
  localparam logic              STOP_EN_RST   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BITS_PER_CHAR  = 3'd0,
    REG_PREAMBLE_ZEROS = 3'd1,
    REG_TRAILER_ZEROS  = 3'd2,
    REG_STOP_CHAR      = 3'd3,
    REG_STOP_ENABLE    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

### design/magstripe_f2f_transmitter.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    in_command, in_char_value
// out      output     out_valid / out_ready  out_first_half_polarity,
//                                            out_second_half_polarity,
//                                            out_bit_value, out_last
// cfg      input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// An item is taken while idle, then one bit cell leaves per cycle, while
// the output is not stalled, from a down-counter and a shift register; an
// item with no cells, such as a dropped character, never leaves idle. A
// character gives up to MAX_CHAR_BITS cells, a start or end up to
// MAX_PAD_CELLS.
// Reset (synchronous, active low) restores the register defaults, clears the
// coil polarity and the sentinel flag, and empties the output register.
// A stalled output simply pauses the cell shifter; the next word is taken
// only once the last cell of the current one has been loaded.
module magstripe_f2f_transmitter #(
  parameter int unsigned MAX_PAD_CELLS = mf2f_pkg::MAX_PAD_CELLS_DEF,
  parameter int unsigned MAX_CHAR_BITS = mf2f_pkg::MAX_CHAR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mf2f_pkg::CMD_W-1:0]      in_command,
  input  logic [mf2f_pkg::CHAR_W-1:0]     in_char_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_first_half_polarity,
  output logic                            out_second_half_polarity,
  output logic                            out_bit_value,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [mf2f_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf2f_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mf2f_pkg::*;

  `include "magstripe_f2f_transmitter_defines.svh"

  localparam int unsigned CNT_W = $clog2(MAX_PAD_CELLS + 1);
  localparam int unsigned BIT_W = $clog2(MAX_CHAR_BITS + 1);
  localparam int unsigned REM_W = (CNT_W > BIT_W) ? CNT_W : BIT_W;
  localparam int unsigned PCMP_W = (CNT_W > PAD_W) ? CNT_W : PAD_W;
  localparam int unsigned BCMP_W = (BIT_W > BPC_W) ? BIT_W : BPC_W;

  // Configuration registers.
  logic [BPC_W-1:0]  bpc_r;
  logic [PAD_W-1:0]  pre_r;
  logic [PAD_W-1:0]  trl_r;
  logic [CHAR_W-1:0] stop_char_r;
  logic              stop_en_r;

  // Control state.
  state_t                   state_r, state_nxt;
  logic                     pol_r, pol_nxt;
  logic                     stop_seen_r, stop_seen_nxt;
  logic                     data_r, data_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [MAX_CHAR_BITS-1:0] shift_r, shift_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Output word.
  logic out_first_r, out_second_r, out_bit_r, out_last_r;

  logic             in_fire;
  logic             out_load;
  logic             cell_bit;
  logic             cell_second;
  logic [REM_W-1:0] pre_cnt, trl_cnt, bit_cnt;
  cmd_t             cmd;

  assign cmd      = cmd_t'(in_command);
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Counts beyond the hardware limits saturate.
  assign pre_cnt = (PCMP_W'(pre_r) > PCMP_W'(MAX_PAD_CELLS)) ?
                   REM_W'(MAX_PAD_CELLS) : REM_W'(pre_r);
  assign trl_cnt = (PCMP_W'(trl_r) > PCMP_W'(MAX_PAD_CELLS)) ?
                   REM_W'(MAX_PAD_CELLS) : REM_W'(trl_r);
  assign bit_cnt = (BCMP_W'(bpc_r) > BCMP_W'(MAX_CHAR_BITS)) ?
                   REM_W'(MAX_CHAR_BITS) : REM_W'(bpc_r);

  assign out_load    = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign cell_bit    = data_r & shift_r[0];
  assign cell_second = pol_r ^ cell_bit;

  always_comb begin
    state_nxt     = state_r;
    pol_nxt       = pol_r;
    stop_seen_nxt = stop_seen_r;
    data_nxt      = data_r;
    rem_nxt       = rem_r;
    shift_nxt     = shift_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_START: begin
              pol_nxt       = 1'b0;
              stop_seen_nxt = 1'b0;
              data_nxt      = 1'b0;
              rem_nxt       = pre_cnt;
              if (pre_cnt != '0) begin
                state_nxt = ST_RUN;
              end
            end
            CMD_CHAR: begin
              // Once the sentinel has gone out, later characters are dropped if stop is enabled.
              if (!(stop_en_r && stop_seen_r)) begin
                data_nxt  = 1'b1;
                rem_nxt   = bit_cnt;
                shift_nxt = in_char_value[MAX_CHAR_BITS-1:0];
                if (in_char_value == stop_char_r) begin
                  stop_seen_nxt = 1'b1;
                end
                if (bit_cnt != '0) begin
                  state_nxt = ST_RUN;
                end
              end
            end
            CMD_END: begin
              data_nxt = 1'b0;
              rem_nxt  = trl_cnt;
              if (trl_cnt != '0) begin
                state_nxt = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          // The polarity always flips at the cell boundary.
          pol_nxt   = ~cell_second;
          rem_nxt   = rem_r - REM_W'(1);
          shift_nxt = shift_r >> 1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r       <= BPC_RST;
      pre_r       <= PREAMBLE_RST;
      trl_r       <= TRAILER_RST;
      stop_char_r <= STOP_CHAR_RST;
      stop_en_r   <= STOP_EN_RST;
      state_r     <= ST_IDLE;
      pol_r       <= 1'b0;
      stop_seen_r <= 1'b0;
      data_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BITS_PER_CHAR:  bpc_r       <= cfg_wdata[BPC_W-1:0];
          REG_PREAMBLE_ZEROS: pre_r       <= cfg_wdata[PAD_W-1:0];
          REG_TRAILER_ZEROS:  trl_r       <= cfg_wdata[PAD_W-1:0];
          REG_STOP_CHAR:      stop_char_r <= cfg_wdata[CHAR_W-1:0];
          REG_STOP_ENABLE:    stop_en_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      pol_r       <= pol_nxt;
      stop_seen_r <= stop_seen_nxt;
      data_r      <= data_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (out_load) begin
      out_first_r  <= pol_r;
      out_second_r <= cell_second;
      out_bit_r    <= cell_bit;
      out_last_r   <= (rem_r == REM_W'(1));
    end
  end

  assign out_valid                = out_valid_r;
  assign out_first_half_polarity  = out_first_r;
  assign out_second_half_polarity = out_second_r;
  assign out_bit_value            = out_bit_r;
  assign out_last                 = out_last_r;

  `MF2F_ASSERT_NEXT(a_last_frees_input, out_load && (rem_r == REM_W'(1)), in_ready, "last cell loaded but input not freed")
  `MF2F_ASSERT_NOW(a_mid_word_running, out_valid_r && !out_last_r, state_r == ST_RUN, "non-final cell pending while idle")
  `MF2F_ASSERT_NEXT(a_boundary_flip, out_load, pol_r == !out_second_r, "polarity did not flip at cell boundary")

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mf2f_pkg::*;

  localparam int unsigned PAD_LIMIT   = MAX_PAD_CELLS_DEF;
  localparam int unsigned BITS_LIMIT  = MAX_CHAR_BITS_DEF;
  localparam int unsigned SETTLE      = 2 * PAD_LIMIT + 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic first_half;
    logic second_half;
    logic data_bit;
    logic last;
  } cell_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command;
  logic [CHAR_W-1:0]     in_char_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_first_half_polarity;
  logic                  out_second_half_polarity;
  logic                  out_bit_value;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor copy of the registers and the coil state.
  logic [BPC_W-1:0]  bits_per_char;
  logic [PAD_W-1:0]  preamble_len;
  logic [PAD_W-1:0]  trailer_len;
  logic [CHAR_W-1:0] sentinel;
  logic              sentinel_drop;
  logic              coil_pol;
  logic              sentinel_seen;

  cell_t       expected_cells[$];
  int unsigned mismatches;
  int unsigned cells_checked;
  int unsigned words_sent;
  int unsigned settings_used;
  int unsigned cycle_count;
  int unsigned hold_request;
  bit          tx_gaps;
  bit          rx_stalls;

  magstripe_f2f_transmitter DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_command               (in_command),
    .in_char_value            (in_char_value),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_first_half_polarity  (out_first_half_polarity),
    .out_second_half_polarity (out_second_half_polarity),
    .out_bit_value            (out_bit_value),
    .out_last                 (out_last),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d cells still awaited", cycle_count,
               expected_cells.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_cell(logic data_bit, logic is_last);
    cell_t c;
    c.first_half  = coil_pol;
    c.second_half = data_bit ? ~coil_pol : coil_pol;
    c.data_bit    = data_bit;
    c.last        = is_last;
    // Every cell boundary flips the coil.
    coil_pol = ~c.second_half;
    expected_cells.push_back(c);
  endfunction

  function automatic void push_zeros(int unsigned count);
    int unsigned n;
    n = (count > PAD_LIMIT) ? PAD_LIMIT : count;
    for (int unsigned k = 0; k < n; k++) push_cell(1'b0, k == n - 1);
  endfunction

  function automatic void encode_word(cmd_t cmd, logic [CHAR_W-1:0] ch);
    int unsigned nbits;
    case (cmd)
      CMD_START: begin
        coil_pol      = 1'b0;
        sentinel_seen = 1'b0;
        push_zeros(32'(preamble_len));
      end
      CMD_CHAR: begin
        if (!(sentinel_drop && sentinel_seen)) begin
          nbits = (32'(bits_per_char) > BITS_LIMIT) ? BITS_LIMIT : 32'(bits_per_char);
          for (int unsigned j = 0; j < nbits; j++) push_cell(ch[j], j == nbits - 1);
          if (ch == sentinel) sentinel_seen = 1'b1;
        end
      end
      CMD_END: push_zeros(32'(trailer_len));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_cells
    cell_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: cell with none expected, expected nothing, got %b%b%b%b", $time,
                 out_first_half_polarity, out_second_half_polarity, out_bit_value,
                 out_last);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        compare_field("first_half_polarity", want.first_half, out_first_half_polarity);
        compare_field("second_half_polarity", want.second_half, out_second_half_polarity);
        compare_field("bit_value", want.data_bit, out_bit_value);
        compare_field("last", want.last, out_last);
        cells_checked++;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin : receiver
    int unsigned hold_len;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Valid is left high after acceptance; the next word replaces it or drain_cells lowers it.
  task automatic send_word(cmd_t cmd, logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_value <= ch;
    do @(posedge clk); while (!in_ready);
    encode_word(cmd, ch);
    words_sent++;
  endtask

  task automatic drain_cells();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    // Words with no cells may still be in flight.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_BITS_PER_CHAR:  bits_per_char = value[BPC_W-1:0];
      REG_PREAMBLE_ZEROS: preamble_len  = value[PAD_W-1:0];
      REG_TRAILER_ZEROS:  trailer_len   = value[PAD_W-1:0];
      REG_STOP_CHAR:      sentinel      = value;
      REG_STOP_ENABLE:    sentinel_drop = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] bpc, logic [7:0] pre, logic [7:0] trl,
                           logic [7:0] stop_ch, logic [7:0] stop_en);
    write_reg(REG_BITS_PER_CHAR, bpc);
    write_reg(REG_PREAMBLE_ZEROS, pre);
    write_reg(REG_TRAILER_ZEROS, trl);
    write_reg(REG_STOP_CHAR, stop_ch);
    write_reg(REG_STOP_ENABLE, stop_en);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_settings();
    logic [7:0] bpc, pre, trl;
    bpc = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(1, 8));
    pre = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 6));
    trl = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 6));
    configure(bpc, pre, trl, 8'($urandom), 8'($urandom_range(0, 1)));
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    return ($urandom_range(0, 5) == 0) ? sentinel : CHAR_W'($urandom);
  endfunction

  // Mostly whole frames with random characters; the rest is loose commands.
  task automatic send_frames(int unsigned n_words);
    int unsigned sent;
    int unsigned n_chars;
    cmd_t        cmd;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 4) == 0) begin
        cmd = cmd_t'(CMD_W'($urandom_range(0, 3)));
        send_word(cmd, pick_char());
        if (cmd != CMD_NONE) sent++;
      end else begin
        n_chars = $urandom_range(1, 6);
        send_word(CMD_START, CHAR_W'($urandom));
        repeat (n_chars) send_word(CMD_CHAR, pick_char());
        send_word(CMD_END, CHAR_W'($urandom));
        sent += n_chars + 2;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    send_word(CMD_START, 8'h00);
    send_word(CMD_CHAR, 8'h41);
    send_word(CMD_CHAR, 8'd70);
    send_word(CMD_CHAR, 8'h42);
    send_word(CMD_END, 8'h00);
    // The end of frame leaves the sentinel flag set.
    send_word(CMD_CHAR, 8'h43);
    send_word(CMD_NONE, 8'hFF);
    drain_cells();
  endtask

  task automatic test_field_extremes();
    configure(8'd8, 8'd32, 8'd32, 8'hFF, 8'd1);
    send_word(CMD_START, 8'hFF);
    send_word(CMD_CHAR, 8'h00);
    send_word(CMD_CHAR, 8'hFF);
    send_word(CMD_CHAR, 8'h55);
    send_word(CMD_END, 8'h00);
    send_word(CMD_START, 8'h00);
    send_word(CMD_CHAR, 8'hAA);
    send_word(CMD_END, 8'h00);
    drain_cells();
    // Oversized counts saturate; sentinel recorded but nothing dropped.
    configure(8'd15, 8'd63, 8'd63, 8'h00, 8'd0);
    send_word(CMD_START, 8'h00);
    send_word(CMD_CHAR, 8'h00);
    send_word(CMD_CHAR, 8'hA5);
    send_word(CMD_END, 8'h00);
    drain_cells();
    // Zero counts give no cells, yet the sentinel and the start still act.
    configure(8'd0, 8'd0, 8'd0, 8'h01, 8'd1);
    send_word(CMD_START, 8'h00);
    send_word(CMD_CHAR, 8'h01);
    send_word(CMD_END, 8'h00);
    drain_cells();
    configure(8'd1, 8'd1, 8'd1, 8'h03, 8'd1);
    send_word(CMD_CHAR, 8'h80);
    send_word(CMD_START, 8'h00);
    send_word(CMD_CHAR, 8'h03);
    send_word(CMD_CHAR, 8'h02);
    send_word(CMD_END, 8'h00);
    drain_cells();
  endtask

  task automatic test_random_frames();
    repeat (4) begin
      random_settings();
      send_frames(20);
      drain_cells();
    end
  endtask

  task automatic test_output_backpressure();
    configure(8'd8, 8'd4, 8'd4, 8'd70, 8'd0);
    tx_gaps      = 1'b0;
    hold_request = 300;
    send_word(CMD_START, 8'h00);
    repeat (12) send_word(CMD_CHAR, CHAR_W'($urandom));
    send_word(CMD_END, 8'h00);
    drain_cells();
  endtask

  task automatic test_steady_stream();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    random_settings();
    send_frames(15);
    drain_cells();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_NONE;
    in_char_value <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_BITS_PER_CHAR;
    cfg_wdata     <= '0;
    cycle_count   = 0;
    mismatches    = 0;
    cells_checked = 0;
    words_sent    = 0;
    settings_used = 1;
    hold_request  = 0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    bits_per_char = BPC_RST;
    preamble_len  = PREAMBLE_RST;
    trailer_len   = TRAILER_RST;
    sentinel      = STOP_CHAR_RST;
    sentinel_drop = STOP_EN_RST;
    coil_pol      = 1'b0;
    sentinel_seen = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_random_frames();
    test_output_backpressure();
    test_steady_stream();

    $display("Sent %0d words under %0d register settings and checked %0d bit cells,",
             words_sent, settings_used, cells_checked);
    $display("with random stalls on both sides, a long receiver hold-off and a steady tail.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mf2f_pkg.sv
design/magstripe_f2f_transmitter.sv
verif/testbench.sv
